// ===== hdl/rcmv_pkg.sv =====
// rcmv_pkg: shared types and constants for the redundant copy majority vote block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rcmv_pkg;

    localparam int BYTE_W     = 8;
    localparam int PACK_W     = 64;
    localparam int CNT_W      = 4;
    localparam int MAX_COPIES = PACK_W / BYTE_W;
    localparam int COPIES_DEF = 8;

    localparam logic [CNT_W-1:0] MIN_VOTES_RST = CNT_W'(5);

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_INVERTED = 2'd1,
        ST_FAIL     = 2'd2
    } t_status;

    typedef logic [BYTE_W-1:0] t_byte;

    // winner of one vote
    typedef struct packed {
        t_byte             value;
        logic [CNT_W-1:0]  count;
    } t_vote;

endpackage

`default_nettype wire

// ===== hdl/rcmv_if.sv =====
// rcmv_in_if, rcmv_out_if: valid/ready channels carrying input and result items
// depends on rcmv_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rcmv_in_if
    import rcmv_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PACK_W-1:0] normal_copies;
    logic [PACK_W-1:0] inverted_copies;
    logic              use_fallback;

    modport source (output valid, normal_copies, inverted_copies, use_fallback, input ready);
    modport sink   (input valid, normal_copies, inverted_copies, use_fallback, output ready);
endinterface

interface rcmv_out_if
    import rcmv_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] value;
    logic [1:0]        status;
    logic [CNT_W-1:0]  winning_votes;

    modport source (output valid, value, status, winning_votes, input ready);
    modport sink   (input valid, value, status, winning_votes, output ready);
endinterface

`default_nettype wire

// ===== hdl/rcmv_lane.sv =====
// rcmv_lane: counts the copies at or after one copy index that equal that copy
// depends on rcmv_pkg
`timescale 1ns / 1ps
`default_nettype none

module rcmv_lane
    import rcmv_pkg::*;
#(
    parameter int COPIES = COPIES_DEF,
    parameter int IDX    = 0
) (
    input  wire t_byte            i_copies [COPIES],
    output logic [CNT_W-1:0]      o_count
);

    always_comb begin
        o_count = '0;
        for (int j = IDX; j < COPIES; j++) begin
            if (i_copies[j] == i_copies[IDX]) begin
                o_count = o_count + CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rcmv_merge.sv =====
// rcmv_merge: picks the lane with the highest count, lowest index on a tie
// depends on rcmv_pkg
`timescale 1ns / 1ps
`default_nettype none

module rcmv_merge
    import rcmv_pkg::*;
#(
    parameter int COPIES = COPIES_DEF
) (
    input  wire t_byte            i_copies [COPIES],
    input  wire logic [CNT_W-1:0] i_counts [COPIES],
    output t_vote                 o_vote
);

    localparam int IDX_W = $clog2(COPIES);

    logic [IDX_W-1:0] best_idx;
    logic [CNT_W-1:0] best_cnt;

    always_comb begin
        best_idx = '0;
        best_cnt = '0;
        for (int k = 0; k < COPIES; k++) begin
            if (i_counts[k] > best_cnt) begin
                best_cnt = i_counts[k];
                best_idx = IDX_W'(k);
            end
        end
        o_vote.value = i_copies[best_idx];
        o_vote.count = best_cnt;
    end

endmodule

`default_nettype wire

// ===== hdl/redundant_copy_majority_vote_top.sv =====
// Majority vote over redundant byte copies.
// Input channel i_in carries an item of eight packed byte copies, eight packed
// bit-inverted copies and a fallback enable; output channel o_out carries the
// decoded byte, a status code and the winning vote count. Both use valid/ready.
// The register min_votes is written through i_cfg_we / i_cfg_wdata; the user
// must write it only while idle, which the block does not enforce. The first
// stage runs one lane per copy for both copy sets in parallel and registers the
// lane counts, the second merges the lanes, applies the min_votes threshold and
// loads the output register. Throughput is one item per cycle unless stalled.
// Each stage holds its item while the next one is full, so a stalled receiver
// stops the pipe only once both stages are full; bubbles are squeezed out.
// Synchronous active-low reset empties both stages and sets min_votes to 5.
// depends on rcmv_pkg, rcmv_if, rcmv_lane, rcmv_merge
`timescale 1ns / 1ps
`default_nettype none

module redundant_copy_majority_vote_top
    import rcmv_pkg::*;
#(
    parameter int COPIES = COPIES_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire [CNT_W-1:0]        i_cfg_wdata,
    rcmv_in_if.sink                i_in,
    rcmv_out_if.source             o_out
);

    logic [CNT_W-1:0] r_min_votes;

    t_byte            norm_bytes [COPIES];
    t_byte            inv_bytes  [COPIES];
    logic [CNT_W-1:0] norm_cnt   [COPIES];
    logic [CNT_W-1:0] inv_cnt    [COPIES];

    logic             r_s1_valid;
    t_byte            r_s1_norm_bytes [COPIES];
    t_byte            r_s1_inv_bytes  [COPIES];
    logic [CNT_W-1:0] r_s1_norm_cnt   [COPIES];
    logic [CNT_W-1:0] r_s1_inv_cnt    [COPIES];
    logic             r_s1_fallback;

    logic             r_s2_valid;
    t_byte            r_value;
    t_status          r_status;
    logic [CNT_W-1:0] r_votes;

    t_vote            norm_vote;
    t_vote            inv_vote;
    t_byte            n_value;
    t_status          n_status;
    logic [CNT_W-1:0] n_votes;

    logic             s1_ready;
    logic             s2_ready;
    logic             s1_load;
    logic             s2_load;

    assign s2_ready   = !r_s2_valid || o_out.ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign s1_load    = i_in.valid && s1_ready;
    assign s2_load    = r_s1_valid && s2_ready;
    assign i_in.ready = s1_ready;

    // lanes, one per copy for each copy set
    for (genvar k = 0; k < COPIES; k++) begin : g_lane
        assign norm_bytes[k] = i_in.normal_copies[k*BYTE_W +: BYTE_W];
        assign inv_bytes[k]  = i_in.inverted_copies[k*BYTE_W +: BYTE_W];

        rcmv_lane #(.COPIES(COPIES), .IDX(k)) u_norm_lane (
            .i_copies (norm_bytes),
            .o_count  (norm_cnt[k])
        );

        rcmv_lane #(.COPIES(COPIES), .IDX(k)) u_inv_lane (
            .i_copies (inv_bytes),
            .o_count  (inv_cnt[k])
        );
    end

    rcmv_merge #(.COPIES(COPIES)) u_norm_merge (
        .i_copies (r_s1_norm_bytes),
        .i_counts (r_s1_norm_cnt),
        .o_vote   (norm_vote)
    );

    rcmv_merge #(.COPIES(COPIES)) u_inv_merge (
        .i_copies (r_s1_inv_bytes),
        .i_counts (r_s1_inv_cnt),
        .o_vote   (inv_vote)
    );

    always_comb begin
        n_value  = '0;
        n_status = ST_FAIL;
        n_votes  = norm_vote.count;
        if (norm_vote.count >= r_min_votes) begin
            n_value  = norm_vote.value;
            n_status = ST_NORMAL;
        end else if (r_s1_fallback) begin
            n_votes = inv_vote.count;
            if (inv_vote.count >= r_min_votes) begin
                n_value  = ~inv_vote.value;
                n_status = ST_INVERTED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_votes <= MIN_VOTES_RST;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_votes <= i_cfg_wdata;
            end
            if (s1_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_norm_bytes <= norm_bytes;
            r_s1_inv_bytes  <= inv_bytes;
            r_s1_norm_cnt   <= norm_cnt;
            r_s1_inv_cnt    <= inv_cnt;
            r_s1_fallback   <= i_in.use_fallback;
        end
        if (s2_load) begin
            r_value  <= n_value;
            r_status <= n_status;
            r_votes  <= n_votes;
        end
    end

    assign o_out.valid         = r_s2_valid;
    assign o_out.value         = r_value;
    assign o_out.status        = r_status;
    assign o_out.winning_votes = r_votes;

`ifndef SYNTH
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_status == ST_FAIL) |-> (r_value == '0))
        else $error("failed vote with nonzero value");

    a_accept_thresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (r_status == ST_NORMAL || r_status == ST_INVERTED))
            |-> (r_votes >= r_min_votes))
        else $error("accepted vote below min_votes");

    a_votes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_votes >= CNT_W'(1) && r_votes <= CNT_W'(COPIES)))
        else $error("winning vote count out of range");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_ready) |=> r_s1_valid)
        else $error("first stage dropped a stalled item");
`endif

endmodule

`default_nettype wire
